// ===== src/ceq_pkg.sv =====
// shared constants, codes and the entry type of the coalescing event queue
`default_nettype none

package ceq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int KIND_W   = 8;
  localparam int WIN_W    = 16;
  localparam int PAY_W    = 32;
  localparam int ENTRY_W  = KIND_W + WIN_W + PAY_W;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;
  localparam int FILL_W     = 7;
  localparam int FILL_LSB   = ENTRY_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_A = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_B = 1'd1;

  localparam logic [KIND_W-1:0] LOW_A_RST = 8'd0;
  localparam logic [KIND_W-1:0] LOW_B_RST = 8'd1;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [OUT_USER_W-1:0] STS_STORED  = 3'd0;
  localparam logic [OUT_USER_W-1:0] STS_COAL    = 3'd1;
  localparam logic [OUT_USER_W-1:0] STS_LOWDROP = 3'd2;
  localparam logic [OUT_USER_W-1:0] STS_OLDDROP = 3'd3;
  localparam logic [OUT_USER_W-1:0] STS_DEQ     = 3'd4;
  localparam logic [OUT_USER_W-1:0] STS_EMPTY   = 3'd5;

  // kind sits in the low bits, as on the stream
  typedef struct packed {
    logic [PAY_W-1:0]  payload;
    logic [WIN_W-1:0]  window;
    logic [KIND_W-1:0] kind;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/ceq_ram.sv =====
// entry store: one write port, one read port with registered read data
`default_nettype none

module ceq_ram #(
  parameter int Depth = ceq_pkg::DEPTH_DEF,
  parameter int Width = ceq_pkg::ENTRY_W,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/coalescing_event_queue_top.sv =====
// coalescing event queue: sequencer, pointers, config registers and result register
//
//  channel | dir | handshake             | contents
//  in_     | in  | in_tvalid/in_tready   | tdata kind/window/payload, tuser action
//  out_    | out | out_tvalid/out_tready | tdata kind/window/payload/fill, tuser status
//  cfg_    | in  | cfg_we                | cfg_addr register index, cfg_wdata value
//
// one transaction at a time: a dequeue goes through DEQ_RD to EMIT, an empty dequeue straight to EMIT,
//   a plain store through PLACE, a coalescing check through COAL, then to EMIT or to PLACE
// full queue: scan and shift go through the entries one after the other
//   because both go through the single read and write port of the entry store
// a finished result sits in the output register while the next transaction enters
// reset clears pointers, count and config; the entry store is not cleared
`default_nettype none

module coalescing_event_queue_top #(
  parameter int QUEUE_DEPTH = ceq_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ceq_pkg::IN_DATA_W-1:0]   in_tdata,   // kind, window, payload
  input  wire logic [ceq_pkg::IN_USER_W-1:0]   in_tuser,   // action
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [ceq_pkg::OUT_DATA_W-1:0]  out_tdata,  // kind, window, payload, fill_level
  output logic      [ceq_pkg::OUT_USER_W-1:0]  out_tuser,  // status
  input  wire logic                            cfg_we,
  input  wire logic [ceq_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [ceq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [PW-1:0] PTR_MAX = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam int FILL_HI = ceq_pkg::FILL_LSB + ceq_pkg::FILL_W - 1;
  localparam int PAD_W = ceq_pkg::OUT_DATA_W - ceq_pkg::ENTRY_W - ceq_pkg::FILL_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEQ_RD = 3'd1;
  localparam logic [2:0] S_COAL   = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic [ceq_pkg::KIND_W-1:0] low_a_r, low_b_r;

  ceq_pkg::entry_t item_r, item_nxt;
  ceq_pkg::entry_t res_data_r, res_data_nxt;
  logic [ceq_pkg::OUT_USER_W-1:0] res_status_r, res_status_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [ceq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [ceq_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic                        mem_we;
  logic [PW-1:0]               mem_waddr;
  ceq_pkg::entry_t             mem_wdata;
  logic [PW-1:0]               mem_raddr;
  logic [ceq_pkg::ENTRY_W-1:0] rd_raw;
  ceq_pkg::entry_t             rd_ent;

  logic [CW-1:0] rd_off;
  logic          rd_tail;
  logic [PW-1:0] head_inc, tail_inc, tail_m1;
  logic [CW-1:0] cnt_last, off_inc;
  logic [CW+ceq_pkg::FILL_W-1:0] cnt_ext;
  ceq_pkg::entry_t in_ev;
  logic          in_act;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[PW-1:0];
  endfunction

  function automatic logic is_low(input logic [ceq_pkg::KIND_W-1:0] k);
    return (k == low_a_r) || (k == low_b_r);
  endfunction

  assign in_ev    = ceq_pkg::entry_t'(in_tdata);
  assign in_act   = in_tuser[0];
  assign rd_ent   = ceq_pkg::entry_t'(rd_raw);
  assign head_inc = (head_r == PTR_MAX) ? '0 : head_r + PW'(1);
  assign tail_inc = (tail_r == PTR_MAX) ? '0 : tail_r + PW'(1);
  assign tail_m1  = (tail_r == '0) ? PTR_MAX : tail_r - PW'(1);
  assign cnt_last = count_r - CW'(1);
  assign off_inc  = off_r + CW'(1);
  assign cnt_ext  = (CW + ceq_pkg::FILL_W)'(count_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign mem_raddr = rd_tail ? tail_m1 : wrap_add(head_r, rd_off);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    off_nxt        = off_r;
    item_nxt       = item_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    mem_we         = 1'b0;
    mem_waddr      = tail_r;
    mem_wdata      = item_r;
    rd_off         = '0;
    rd_tail        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          item_nxt     = in_ev;
          res_data_nxt = '0;
          if (in_act == ceq_pkg::ACT_DEQ) begin
            if (count_r == '0) begin
              res_status_nxt = ceq_pkg::STS_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_DEQ_RD;
            end
          end else if (count_r != '0 && is_low(in_ev.kind)) begin
            rd_tail   = 1'b1;
            state_nxt = S_COAL;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end
      S_DEQ_RD: begin
        res_data_nxt   = rd_ent;
        res_status_nxt = ceq_pkg::STS_DEQ;
        head_nxt       = head_inc;
        count_nxt      = cnt_last;
        state_nxt      = S_EMIT;
      end
      S_COAL: begin
        if (rd_ent.kind == item_r.kind && rd_ent.window == item_r.window) begin
          mem_we         = 1'b1;
          mem_waddr      = tail_m1;
          res_status_nxt = ceq_pkg::STS_COAL;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        if (count_r != DEPTH_C) begin
          mem_we         = 1'b1;
          tail_nxt       = tail_inc;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ceq_pkg::STS_STORED;
          state_nxt      = S_EMIT;
        end else begin
          // full: start scanning from the head
          off_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // rd_ent holds entry off_r, the read of off_r+1 goes out now
        rd_off = off_inc;
        if (is_low(rd_ent.kind)) begin
          state_nxt = (off_r == cnt_last) ? S_FINAL : S_SHIFT;
        end else if (off_r == cnt_last) begin
          // no low-priority entry: overwrite the oldest
          mem_we         = 1'b1;
          head_nxt       = head_inc;
          tail_nxt       = tail_inc;
          res_status_nxt = ceq_pkg::STS_OLDDROP;
          state_nxt      = S_EMIT;
        end else begin
          off_nxt = off_inc;
        end
      end
      S_SHIFT: begin
        // rd_ent holds entry off_r+1, moved one place toward the head
        rd_off    = off_r + CW'(2);
        mem_we    = 1'b1;
        mem_waddr = wrap_add(head_r, off_r);
        mem_wdata = rd_ent;
        off_nxt   = off_inc;
        if (off_inc == cnt_last) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        mem_we         = 1'b1;
        mem_waddr      = tail_m1;
        res_status_nxt = ceq_pkg::STS_LOWDROP;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{PAD_W{1'b0}}, cnt_ext[ceq_pkg::FILL_W-1:0], res_data_r};
          out_user_nxt  = res_status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
      low_a_r     <= ceq_pkg::LOW_A_RST;
      low_b_r     <= ceq_pkg::LOW_B_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          ceq_pkg::REG_LOW_A: low_a_r <= cfg_wdata;
          ceq_pkg::REG_LOW_B: low_b_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  ceq_ram #(
    .Depth (QUEUE_DEPTH),
    .Width (ceq_pkg::ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_raw)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above queue depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> wrap_add(head_r, count_r) == tail_r)
    else $error("head, tail and count disagree");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before the transaction finished");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r == ceq_pkg::STS_EMPTY) |->
      out_data_r[FILL_HI:ceq_pkg::FILL_LSB] == '0)
    else $error("empty status with nonzero fill level");

  a_coal_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r == ceq_pkg::STS_COAL) |->
      out_data_r[FILL_HI:ceq_pkg::FILL_LSB] != '0)
    else $error("coalesced into an empty queue");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the coalescing event queue
`timescale 1ns / 1ps

module testbench;

  localparam int QD = ceq_pkg::DEPTH_DEF;

  typedef struct packed {
    logic            act;
    ceq_pkg::entry_t ent;
  } event_item_t;

  typedef struct packed {
    logic [ceq_pkg::OUT_USER_W-1:0] status;
    logic [ceq_pkg::FILL_W-1:0]     fill;
    ceq_pkg::entry_t                ent;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ceq_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [ceq_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ceq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [ceq_pkg::OUT_USER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [ceq_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [ceq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  event_item_t events_to_send[$];
  queue_result_t predicted_results[$];

  // predictor state
  ceq_pkg::entry_t ev_store[QD];
  int ev_head, ev_tail, ev_count;
  logic [ceq_pkg::KIND_W-1:0] low_kind_a, low_kind_b;

  int errors = 0;
  int inputs_taken = 0;
  bit in_taken = 1'b0;
  bit quiet = 1'b0;
  int in_gap = 0;
  int rdy_gap = 0;
  int long_left = 0;
  bit long_done = 1'b0;

  coalescing_event_queue_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit kind_is_low(logic [ceq_pkg::KIND_W-1:0] k);
    return k == low_kind_a || k == low_kind_b;
  endfunction

  function automatic queue_result_t predict_queue_step(logic act, ceq_pkg::entry_t ev);
    queue_result_t r;
    int last, found, i;
    bit merged;
    r = '0;
    merged = 1'b0;
    if (act == ceq_pkg::ACT_ENQ) begin
      if (ev_count > 0 && kind_is_low(ev.kind)) begin
        last = (ev_tail + QD - 1) % QD;
        if (ev_store[last].kind == ev.kind && ev_store[last].window == ev.window) begin
          ev_store[last] = ev;
          merged = 1'b1;
        end
      end
      if (merged) begin
        r.status = ceq_pkg::STS_COAL;
      end else begin
        r.status = ceq_pkg::STS_STORED;
        if (ev_count >= QD) begin
          found = -1;
          for (i = 0; i < ev_count; i++)
            if (found < 0 && kind_is_low(ev_store[(ev_head + i) % QD].kind))
              found = i;
          if (found >= 0) begin
            // close the gap left by the dropped low-priority entry
            for (i = found; i + 1 < ev_count; i++)
              ev_store[(ev_head + i) % QD] = ev_store[(ev_head + i + 1) % QD];
            ev_tail = (ev_tail + QD - 1) % QD;
            ev_count--;
            r.status = ceq_pkg::STS_LOWDROP;
          end else begin
            ev_head = (ev_head + 1) % QD;
            ev_count--;
            r.status = ceq_pkg::STS_OLDDROP;
          end
        end
        ev_store[ev_tail] = ev;
        ev_tail = (ev_tail + 1) % QD;
        ev_count++;
      end
    end else if (ev_count == 0) begin
      r.status = ceq_pkg::STS_EMPTY;
    end else begin
      r.ent = ev_store[ev_head];
      ev_head = (ev_head + 1) % QD;
      ev_count--;
      r.status = ceq_pkg::STS_DEQ;
    end
    r.fill = ev_count[ceq_pkg::FILL_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string what, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // input side: register writes and accepted transactions feed the predictor
  always @(posedge clk) begin
    event_item_t it;
    if (!rst_n) begin
      ev_head = 0;
      ev_tail = 0;
      ev_count = 0;
      low_kind_a = ceq_pkg::LOW_A_RST;
      low_kind_b = ceq_pkg::LOW_B_RST;
      in_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ceq_pkg::REG_LOW_A: low_kind_a = cfg_wdata;
          ceq_pkg::REG_LOW_B: low_kind_b = cfg_wdata;
          default: ;
        endcase
      end
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        it = events_to_send.pop_front();
        predicted_results.push_back(predict_queue_step(it.act, it.ent));
        inputs_taken++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      in_gap = $urandom_range(1, 11) - 1;
      in_tvalid <= 1'b0;
    end else if (events_to_send.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= events_to_send[0].ent;
      in_tuser <= events_to_send[0].act;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver ready, with one long hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_left > 0) begin
      out_tready <= 1'b0;
      long_left--;
    end else if (!long_done && inputs_taken >= 150) begin
      long_done = 1'b1;
      long_left = 400;
      out_tready <= 1'b0;
    end else if (rdy_gap > 0) begin
      out_tready <= 1'b0;
      rdy_gap--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rdy_gap = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    queue_result_t want;
    ceq_pkg::entry_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[ceq_pkg::ENTRY_W-1:0];
      if (predicted_results.size() == 0) begin
        errors++;
        $display("%0t: result transaction with none expected, status %0d", $time, out_tuser);
      end else begin
        want = predicted_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_tuser));
        check_field("kind", 64'(want.ent.kind), 64'(got.kind));
        check_field("window", 64'(want.ent.window), 64'(got.window));
        check_field("payload", 64'(want.ent.payload), 64'(got.payload));
        check_field("fill_level", 64'(want.fill),
                    64'(out_tdata[ceq_pkg::FILL_LSB +: ceq_pkg::FILL_W]));
      end
    end
  end

  task automatic push_event(logic act, logic [ceq_pkg::KIND_W-1:0] k,
                            logic [ceq_pkg::WIN_W-1:0] w, logic [ceq_pkg::PAY_W-1:0] p);
    event_item_t it;
    it.act = act;
    it.ent.kind = k;
    it.ent.window = w;
    it.ent.payload = p;
    events_to_send.push_back(it);
  endtask

  task automatic write_reg(logic [ceq_pkg::CFG_IDX_W-1:0] idx,
                           logic [ceq_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (events_to_send.size() != 0 || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  // runs of fill, low-free fill, drain and noise traffic
  task automatic gen_traffic(int n, logic [ceq_pkg::KIND_W-1:0] la,
                             logic [ceq_pkg::KIND_W-1:0] lb);
    event_item_t it;
    int made, len, mode, k;
    logic [31:0] rnd;
    logic [ceq_pkg::KIND_W-1:0] prev_kind;
    logic [ceq_pkg::WIN_W-1:0] prev_win;
    made = 0;
    prev_kind = la;
    prev_win = '0;
    while (made < n) begin
      mode = $urandom_range(0, 3);
      len = (mode == 1) ? $urandom_range(70, 140) : $urandom_range(20, 90);
      for (k = 0; k < len && made < n; k++) begin
        rnd = $urandom;
        it.ent.kind = rnd[ceq_pkg::KIND_W-1:0];
        rnd = $urandom;
        it.ent.window = rnd[ceq_pkg::WIN_W-1:0];
        rnd = $urandom;
        it.ent.payload = rnd[ceq_pkg::PAY_W-1:0];
        case (mode)
          0: begin
            it.act = ($urandom_range(0, 9) == 0) ? ceq_pkg::ACT_DEQ : ceq_pkg::ACT_ENQ;
            if ($urandom_range(0, 2) == 0) begin
              it.ent.kind = prev_kind;
              it.ent.window = prev_win;
            end else if ($urandom_range(0, 1) == 1) begin
              it.ent.kind = ($urandom_range(0, 1) == 1) ? la : lb;
              rnd = $urandom_range(0, 3);
              it.ent.window = rnd[ceq_pkg::WIN_W-1:0];
            end
          end
          1: begin
            it.act = ($urandom_range(0, 19) == 0) ? ceq_pkg::ACT_DEQ : ceq_pkg::ACT_ENQ;
            while (it.ent.kind == la || it.ent.kind == lb)
              it.ent.kind++;
          end
          2: it.act = ($urandom_range(0, 99) < 85) ? ceq_pkg::ACT_DEQ : ceq_pkg::ACT_ENQ;
          default: it.act = ($urandom_range(0, 1) == 1) ? ceq_pkg::ACT_DEQ : ceq_pkg::ACT_ENQ;
        endcase
        if (it.act == ceq_pkg::ACT_ENQ) begin
          prev_kind = it.ent.kind;
          prev_win = it.ent.window;
        end
        events_to_send.push_back(it);
        made++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: default low-priority kinds 0 and 1
    push_event(ceq_pkg::ACT_DEQ, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_event(ceq_pkg::ACT_ENQ, 8'h00, 16'h0000, 32'h0000_0000);
    push_event(ceq_pkg::ACT_ENQ, 8'h00, 16'h0000, 32'hFFFF_FFFF);
    push_event(ceq_pkg::ACT_ENQ, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_event(ceq_pkg::ACT_ENQ, 8'h01, 16'hFFFF, 32'h0000_0005);
    push_event(ceq_pkg::ACT_ENQ, 8'h01, 16'hFFFF, 32'h0000_0006);
    push_event(ceq_pkg::ACT_ENQ, 8'h01, 16'hFFFE, 32'h0000_0007);
    push_event(ceq_pkg::ACT_ENQ, 8'h00, 16'hFFFE, 32'hA5A5_A5A5);
    push_event(ceq_pkg::ACT_ENQ, 8'h02, 16'h1234, 32'h0000_0001);
    push_event(ceq_pkg::ACT_ENQ, 8'h02, 16'h1234, 32'h0000_0002);
    repeat (7) push_event(ceq_pkg::ACT_DEQ, 8'h00, 16'h0000, 32'h0000_0000);
    push_event(ceq_pkg::ACT_DEQ, 8'h5A, 16'hA5A5, 32'h5A5A_A5A5);
    wait_drained();

    write_reg(ceq_pkg::REG_LOW_A, 8'hFF);
    write_reg(ceq_pkg::REG_LOW_B, 8'h00);
    gen_traffic(250, 8'hFF, 8'h00);
    wait_drained();

    // both registers on one kind; entries already queued are reclassified
    write_reg(ceq_pkg::REG_LOW_A, 8'h5A);
    write_reg(ceq_pkg::REG_LOW_B, 8'h5A);
    gen_traffic(200, 8'h5A, 8'h5A);
    wait_drained();

    write_reg(ceq_pkg::REG_LOW_A, 8'h00);
    write_reg(ceq_pkg::REG_LOW_B, 8'hFF);
    gen_traffic(200, 8'h00, 8'hFF);
    wait_drained();

    // last stretch runs at full rate on both sides, as far as the block's busy states let it
    quiet = 1'b1;
    write_reg(ceq_pkg::REG_LOW_A, 8'h12);
    write_reg(ceq_pkg::REG_LOW_B, 8'h34);
    gen_traffic(150, 8'h12, 8'h34);
    wait_drained();

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
